@@ design/lrfp_pkg.sv @@
// lrfp_pkg: shared types and constants for the sensor response frame parser
// frame marker bytes, command codes, result status codes and parser phases
// used by lidar_response_frame_parser_unit; no dependencies

package lrfp_pkg;

  // frame marker bytes
  localparam logic [7:0] HDR_FIRST  = 8'h55;
  localparam logic [7:0] HDR_SECOND = 8'hAA;
  localparam logic [7:0] END_MARK   = 8'hFA;

  // response command codes
  localparam logic [7:0] CMD_MEASURE = 8'h81;
  localparam logic [7:0] CMD_RESET   = 8'h84;
  localparam logic [7:0] CMD_FACTORY = 8'h85;
  localparam logic [7:0] CMD_PRODUCT = 8'h86;

  // header, command, length and end byte around the payload
  localparam int unsigned FRAME_OVERHEAD = 5;

  // payload bytes that are kept per frame
  localparam int unsigned STORE_DEPTH = 7;
  localparam int unsigned STORE_IDX_W = 3;

  // result channel widths
  localparam int unsigned OUT_DATA_W = 104;
  localparam int unsigned STATUS_W   = 3;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_MEASURE = 3'd0,
    ST_RESET   = 3'd1,
    ST_FACTORY = 3'd2,
    ST_PRODUCT = 3'd3,
    ST_UNKNOWN = 3'd4
  } status_t;

  // parser phases, one-hot
  typedef enum logic [5:0] {
    PH_HDR1 = 6'b000001,
    PH_HDR2 = 6'b000010,
    PH_CMD  = 6'b000100,
    PH_LEN  = 6'b001000,
    PH_DATA = 6'b010000,
    PH_END  = 6'b100000
  } phase_t;

endpackage

@@ design/lidar_response_frame_parser_unit.sv @@
// lidar_response_frame_parser_unit: byte-wise parser for sensor response frames
// keeps the sensor record and emits one result per completed frame
// depends on lrfp_pkg for marker bytes, command codes, status codes and phases
//
// usage:
//   in_*  : one received serial byte per transaction in in_tdata
//   out_* : one result per frame 0x55 0xAA cmd len payload 0xFA; out_tuser
//           holds the frame status, out_tdata the whole kept sensor record
//           after the frame has updated it
// result: registered, valid in the cycle after the end byte is accepted
// throughput: one byte per cycle while in_tready is high; the parser state and the result register
//   are updated in the same cycle that a byte is accepted
// stall: a result waits in the output register while out_tready is low; in that
//   time in_tready is low, and it rises again in the cycle the result is taken
// reset: synchronous, active low; the parser hunts for a first header byte, the
//   payload store and kept record read as zero, and no result is pending
// malformed frames (length too large, wrong second header or end byte) give no
//   result; a 0x55 in place of the second header or end byte starts a new frame

module lidar_response_frame_parser_unit #(
  parameter int unsigned MAX_FRAME_BYTES = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input byte stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // [7:0] rx_byte
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [15:0] distance_mm, [23:16] error_code, [31:24] offset_short_a,
  // [39:32] offset_short_b, [47:40] offset_long_a, [55:48] offset_long_b,
  // [71:56] crosstalk_value, [79:72] calibration_state, [87:80] product_type,
  // [95:88] port_mode, [103:96] firmware_version
  output logic [lrfp_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic [lrfp_pkg::STATUS_W-1:0]     out_tuser   // [2:0] frame_status
);

  localparam logic [8:0] MaxFrame = 9'(MAX_FRAME_BYTES);
  localparam logic [8:0] Overhead = 9'(lrfp_pkg::FRAME_OVERHEAD);

  // parser state
  lrfp_pkg::phase_t phase_r, phase_nxt;
  logic [7:0] cmd_r, cmd_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic [7:0] store_r   [lrfp_pkg::STORE_DEPTH];
  logic [7:0] store_nxt [lrfp_pkg::STORE_DEPTH];

  // kept sensor record
  logic [15:0] distance_r, distance_nxt;
  logic [7:0]  error_r, error_nxt;
  logic [7:0]  offset_r   [4];
  logic [7:0]  offset_nxt [4];
  logic [15:0] xtalk_r, xtalk_nxt;
  logic [7:0]  calib_r, calib_nxt;
  logic [7:0]  product_r   [3];
  logic [7:0]  product_nxt [3];

  // result register
  logic                              out_valid_r;
  logic [lrfp_pkg::OUT_DATA_W-1:0]   out_data_r;
  logic [lrfp_pkg::STATUS_W-1:0]     out_user_r;

  logic             in_accept;
  logic             emit;
  lrfp_pkg::status_t status;
  logic [7:0]       rx;
  logic             len_too_big;

  assign rx        = in_tdata;
  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;

  assign len_too_big = ({1'b0, rx} + Overhead) > MaxFrame;

  // next parser state and kept record for the accepted byte
  always_comb begin
    phase_nxt    = phase_r;
    cmd_nxt      = cmd_r;
    len_nxt      = len_r;
    cnt_nxt      = cnt_r;
    store_nxt    = store_r;
    distance_nxt = distance_r;
    error_nxt    = error_r;
    offset_nxt   = offset_r;
    xtalk_nxt    = xtalk_r;
    calib_nxt    = calib_r;
    product_nxt  = product_r;
    emit         = 1'b0;
    status       = lrfp_pkg::ST_MEASURE;

    unique case (phase_r)
      lrfp_pkg::PH_HDR2: begin
        if (rx == lrfp_pkg::HDR_SECOND) begin
          phase_nxt = lrfp_pkg::PH_CMD;
        end else if (rx == lrfp_pkg::HDR_FIRST) begin
          phase_nxt = lrfp_pkg::PH_HDR2;
          cmd_nxt   = '0;
          len_nxt   = '0;
          cnt_nxt   = '0;
          for (int i = 0; i < lrfp_pkg::STORE_DEPTH; i++) store_nxt[i] = '0;
        end else begin
          phase_nxt = lrfp_pkg::PH_HDR1;
        end
      end
      lrfp_pkg::PH_CMD: begin
        cmd_nxt   = rx;
        phase_nxt = lrfp_pkg::PH_LEN;
      end
      lrfp_pkg::PH_LEN: begin
        if (len_too_big) begin
          phase_nxt = lrfp_pkg::PH_HDR1;
        end else begin
          len_nxt   = rx;
          cnt_nxt   = '0;
          phase_nxt = (rx != 8'd0) ? lrfp_pkg::PH_DATA : lrfp_pkg::PH_END;
        end
      end
      lrfp_pkg::PH_DATA: begin
        // keep the first payload bytes, count the rest
        for (int i = 0; i < lrfp_pkg::STORE_DEPTH; i++) begin
          if (cnt_r == 8'(i)) store_nxt[i] = rx;
        end
        if (cnt_r != 8'hFF) cnt_nxt = cnt_r + 8'd1;
        if (cnt_nxt >= len_r) phase_nxt = lrfp_pkg::PH_END;
      end
      lrfp_pkg::PH_END: begin
        if (rx == lrfp_pkg::END_MARK) begin
          phase_nxt = lrfp_pkg::PH_HDR1;
          emit      = 1'b1;
          // decode the command and update the kept record
          unique case (cmd_r)
            lrfp_pkg::CMD_MEASURE: begin
              distance_nxt = {store_r[0], store_r[1]};
              error_nxt    = store_r[2];
              status       = lrfp_pkg::ST_MEASURE;
            end
            lrfp_pkg::CMD_RESET: begin
              status = lrfp_pkg::ST_RESET;
            end
            lrfp_pkg::CMD_FACTORY: begin
              for (int i = 0; i < 4; i++) offset_nxt[i] = store_r[i];
              xtalk_nxt = {store_r[4], store_r[5]};
              calib_nxt = store_r[6];
              status    = lrfp_pkg::ST_FACTORY;
            end
            lrfp_pkg::CMD_PRODUCT: begin
              for (int i = 0; i < 3; i++) product_nxt[i] = store_r[i];
              status = lrfp_pkg::ST_PRODUCT;
            end
            default: begin
              status = lrfp_pkg::ST_UNKNOWN;
            end
          endcase
        end else if (rx == lrfp_pkg::HDR_FIRST) begin
          phase_nxt = lrfp_pkg::PH_HDR2;
          cmd_nxt   = '0;
          len_nxt   = '0;
          cnt_nxt   = '0;
          for (int i = 0; i < lrfp_pkg::STORE_DEPTH; i++) store_nxt[i] = '0;
        end else begin
          phase_nxt = lrfp_pkg::PH_HDR1;
        end
      end
      default: begin
        // hunting for the first header byte
        if (rx == lrfp_pkg::HDR_FIRST) begin
          phase_nxt = lrfp_pkg::PH_HDR2;
          cmd_nxt   = '0;
          len_nxt   = '0;
          cnt_nxt   = '0;
          for (int i = 0; i < lrfp_pkg::STORE_DEPTH; i++) store_nxt[i] = '0;
        end else begin
          phase_nxt = lrfp_pkg::PH_HDR1;
        end
      end
    endcase
  end

  // parser state and kept record
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= lrfp_pkg::PH_HDR1;
      cmd_r      <= '0;
      len_r      <= '0;
      cnt_r      <= '0;
      for (int i = 0; i < lrfp_pkg::STORE_DEPTH; i++) store_r[i] <= '0;
      distance_r <= '0;
      error_r    <= '0;
      for (int i = 0; i < 4; i++) offset_r[i] <= '0;
      xtalk_r    <= '0;
      calib_r    <= '0;
      for (int i = 0; i < 3; i++) product_r[i] <= '0;
    end else if (in_accept) begin
      phase_r    <= phase_nxt;
      cmd_r      <= cmd_nxt;
      len_r      <= len_nxt;
      cnt_r      <= cnt_nxt;
      store_r    <= store_nxt;
      distance_r <= distance_nxt;
      error_r    <= error_nxt;
      offset_r   <= offset_nxt;
      xtalk_r    <= xtalk_nxt;
      calib_r    <= calib_nxt;
      product_r  <= product_nxt;
    end
  end

  // result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_accept && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload, loaded with the updated record
  always_ff @(posedge clk) begin
    if (in_accept && emit) begin
      out_user_r <= status;
      out_data_r <= {product_nxt[2], product_nxt[1], product_nxt[0], calib_nxt, xtalk_nxt,
                     offset_nxt[3], offset_nxt[2], offset_nxt[1], offset_nxt[0],
                     error_nxt, distance_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

`ifndef ASSERT_OFF
  // the payload counter never reaches the length while payload bytes are due
  a_count_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == lrfp_pkg::PH_DATA) |-> (cnt_r < len_r))
    else $error("payload counter reached length in data phase");

  // a frame past the length check always fits the frame limit
  a_len_fits: assert property (@(posedge clk) disable iff (!rst_n)
    ((phase_r == lrfp_pkg::PH_DATA) || (phase_r == lrfp_pkg::PH_END))
      |-> (({1'b0, len_r} + Overhead) <= MaxFrame))
    else $error("accepted length exceeds the frame limit");

  // a new result follows only an accepted end byte in the end phase
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(in_accept) && ($past(phase_r) == lrfp_pkg::PH_END)
      && ($past(rx) == lrfp_pkg::END_MARK)))
    else $error("result raised without a completed frame");

  // after a completed frame the parser hunts for a header again
  a_hunt_after_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && emit) |=> (phase_r == lrfp_pkg::PH_HDR1))
    else $error("parser not back in header hunt after a frame");
`endif

endmodule

@@ tb/sv/lidar_response_frame_parser_unit_tb.sv @@
// lidar_response_frame_parser_unit_tb: self-checking bench for the sensor response frame parser
// drives serial bytes as stream transactions and checks every result against a
// predicted sensor record; depends on lrfp_pkg and lidar_response_frame_parser_unit
`timescale 1ns / 1ps

module lidar_response_frame_parser_unit_tb;

  localparam int unsigned MAX_FRAME_BYTES = 32;
  localparam int unsigned RANDOM_BYTES    = 1850;
  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES    = 10;

  // one result: frame status plus the whole kept record
  typedef struct {
    lrfp_pkg::status_t status;
    logic [15:0]       distance;
    logic [7:0]        error_code;
    logic [7:0]        offsets [4];
    logic [15:0]       crosstalk;
    logic [7:0]        calibration;
    logic [7:0]        product [3];
  } sensor_result_t;

  // frame parser prediction and result scoreboard
  class sensor_record_tracker;
    lrfp_pkg::phase_t parse_state;
    logic [7:0]       command;
    logic [7:0]       length;
    logic [7:0]       count;
    logic [7:0]       payload_bytes [lrfp_pkg::STORE_DEPTH];
    sensor_result_t   kept;
    sensor_result_t   pending_records [$];
    int unsigned      mismatches;

    function new();
      parse_state = lrfp_pkg::PH_HDR1;
      command     = '0;
      length      = '0;
      count       = '0;
      foreach (payload_bytes[i]) payload_bytes[i] = '0;
      kept.status      = lrfp_pkg::ST_MEASURE;
      kept.distance    = '0;
      kept.error_code  = '0;
      foreach (kept.offsets[i]) kept.offsets[i] = '0;
      kept.crosstalk   = '0;
      kept.calibration = '0;
      foreach (kept.product[i]) kept.product[i] = '0;
      mismatches  = 0;
    endfunction

    // first header byte clears the payload store
    function void hunt_header(logic [7:0] b);
      if (b == lrfp_pkg::HDR_FIRST) begin
        foreach (payload_bytes[i]) payload_bytes[i] = '0;
        count       = '0;
        length      = '0;
        command     = '0;
        parse_state = lrfp_pkg::PH_HDR2;
      end else begin
        parse_state = lrfp_pkg::PH_HDR1;
      end
    endfunction

    // advance the parser by one accepted byte transaction
    function void take_byte(logic [7:0] b);
      case (parse_state)
        lrfp_pkg::PH_HDR2: begin
          if (b == lrfp_pkg::HDR_SECOND) parse_state = lrfp_pkg::PH_CMD;
          else hunt_header(b);
        end
        lrfp_pkg::PH_CMD: begin
          command     = b;
          parse_state = lrfp_pkg::PH_LEN;
        end
        lrfp_pkg::PH_LEN: begin
          if (int'(b) + lrfp_pkg::FRAME_OVERHEAD > MAX_FRAME_BYTES) begin
            parse_state = lrfp_pkg::PH_HDR1;
          end else begin
            length      = b;
            count       = '0;
            parse_state = (b != 0) ? lrfp_pkg::PH_DATA : lrfp_pkg::PH_END;
          end
        end
        lrfp_pkg::PH_DATA: begin
          // bytes past the store are counted and discarded
          if (count < lrfp_pkg::STORE_DEPTH) payload_bytes[count] = b;
          if (count != 8'hFF) count = count + 1;
          if (count >= length) parse_state = lrfp_pkg::PH_END;
        end
        lrfp_pkg::PH_END: begin
          if (b != lrfp_pkg::END_MARK) begin
            hunt_header(b);
          end else begin
            parse_state = lrfp_pkg::PH_HDR1;
            case (command)
              lrfp_pkg::CMD_MEASURE: begin
                kept.status     = lrfp_pkg::ST_MEASURE;
                kept.distance   = {payload_bytes[0], payload_bytes[1]};
                kept.error_code = payload_bytes[2];
              end
              lrfp_pkg::CMD_RESET: kept.status = lrfp_pkg::ST_RESET;
              lrfp_pkg::CMD_FACTORY: begin
                kept.status = lrfp_pkg::ST_FACTORY;
                for (int i = 0; i < 4; i++) kept.offsets[i] = payload_bytes[i];
                kept.crosstalk   = {payload_bytes[4], payload_bytes[5]};
                kept.calibration = payload_bytes[6];
              end
              lrfp_pkg::CMD_PRODUCT: begin
                kept.status = lrfp_pkg::ST_PRODUCT;
                for (int i = 0; i < 3; i++) kept.product[i] = payload_bytes[i];
              end
              default: kept.status = lrfp_pkg::ST_UNKNOWN;
            endcase
            pending_records.push_back(kept);
          end
        end
        default: hunt_header(b);
      endcase
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
        mismatches++;
      end
    endfunction

    // compare one accepted result transaction with the oldest prediction
    function void check_result(logic [lrfp_pkg::STATUS_W-1:0] tuser,
                               logic [lrfp_pkg::OUT_DATA_W-1:0] tdata);
      sensor_result_t want;
      if (pending_records.size() == 0) begin
        $error("result with no frame pending: status 0x%0h", tuser);
        mismatches++;
        return;
      end
      want = pending_records.pop_front();
      compare_field("frame_status",      want.status,      tuser);
      compare_field("distance_mm",       want.distance,    tdata[15:0]);
      compare_field("error_code",        want.error_code,  tdata[23:16]);
      compare_field("offset_short_a",    want.offsets[0],  tdata[31:24]);
      compare_field("offset_short_b",    want.offsets[1],  tdata[39:32]);
      compare_field("offset_long_a",     want.offsets[2],  tdata[47:40]);
      compare_field("offset_long_b",     want.offsets[3],  tdata[55:48]);
      compare_field("crosstalk_value",   want.crosstalk,   tdata[71:56]);
      compare_field("calibration_state", want.calibration, tdata[79:72]);
      compare_field("product_type",      want.product[0],  tdata[87:80]);
      compare_field("port_mode",         want.product[1],  tdata[95:88]);
      compare_field("firmware_version",  want.product[2],  tdata[103:96]);
    endfunction

    function int unsigned pending();
      return pending_records.size();
    endfunction
  endclass

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [7:0]                      in_tdata   = 8'h00;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [lrfp_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [lrfp_pkg::STATUS_W-1:0]   out_tuser;

  sensor_record_tracker record_book;
  int unsigned          send_idle_pct = 13;
  int unsigned          recv_idle_pct = 50;
  int unsigned          sent_bytes    = 0;
  int unsigned          quiet_cycles  = 0;
  logic [7:0]           payload_q [$];

  lidar_response_frame_parser_unit #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #10 clk = ~clk;

  // receiver stalls, transaction monitor and watchdog
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
    if (rst_n) begin
      if (in_tvalid && in_tready) record_book.take_byte(in_tdata);
      if (out_tvalid && out_tready) record_book.check_result(out_tuser, out_tdata);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("lidar_response_frame_parser_unit regression: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // random byte biased toward markers and extremes
  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    b = 8'($urandom);
    if ($urandom_range(99) < 25) begin
      case ($urandom_range(4))
        0: b = 8'h00;
        1: b = 8'hFF;
        2: b = lrfp_pkg::HDR_FIRST;
        3: b = lrfp_pkg::HDR_SECOND;
        default: b = lrfp_pkg::END_MARK;
      endcase
    end
    return b;
  endfunction

  // one byte transaction with random sender gaps
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    sent_bytes++;
  endtask

  task automatic fill_payload(input int unsigned n);
    repeat (n) payload_q.push_back(pick_byte());
  endtask

  // header, command, length, queued payload and end byte
  task automatic send_frame(input logic [7:0] cmd, input logic [7:0] len,
                            input logic [7:0] end_byte);
    send_byte(lrfp_pkg::HDR_FIRST);
    send_byte(lrfp_pkg::HDR_SECOND);
    send_byte(cmd);
    send_byte(len);
    while (payload_q.size() != 0) send_byte(payload_q.pop_front());
    send_byte(end_byte);
  endtask

  initial begin
    logic [7:0]  cmd;
    logic [7:0]  len;
    int unsigned roll;

    record_book = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // noise before any header
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(lrfp_pkg::END_MARK);
    // measurement with an end marker inside the payload
    payload_q = '{8'h12, 8'h34, lrfp_pkg::END_MARK};
    send_frame(lrfp_pkg::CMD_MEASURE, 8'd3, lrfp_pkg::END_MARK);
    send_frame(lrfp_pkg::CMD_RESET, 8'd0, lrfp_pkg::END_MARK);
    payload_q = '{8'h00, 8'hFF, lrfp_pkg::HDR_FIRST, lrfp_pkg::HDR_SECOND, 8'h01, 8'h80,
                  8'hFF};
    send_frame(lrfp_pkg::CMD_FACTORY, 8'd7, lrfp_pkg::END_MARK);
    payload_q = '{8'hFF, 8'h55, 8'h00};
    send_frame(lrfp_pkg::CMD_PRODUCT, 8'd3, lrfp_pkg::END_MARK);
    // unknown commands
    payload_q = '{8'hFF};
    send_frame(8'h82, 8'd1, lrfp_pkg::END_MARK);
    send_frame(8'h83, 8'd0, lrfp_pkg::END_MARK);
    send_frame(8'h00, 8'd0, lrfp_pkg::END_MARK);
    send_frame(8'hFF, 8'd0, lrfp_pkg::END_MARK);
    // short payload leaves zeros, longest payload keeps only the first bytes
    payload_q = '{8'hAB, 8'hCD};
    send_frame(lrfp_pkg::CMD_FACTORY, 8'd2, lrfp_pkg::END_MARK);
    fill_payload(MAX_FRAME_BYTES - lrfp_pkg::FRAME_OVERHEAD);
    send_frame(lrfp_pkg::CMD_MEASURE, 8'(MAX_FRAME_BYTES - lrfp_pkg::FRAME_OVERHEAD),
               lrfp_pkg::END_MARK);
    // length one past the limit and at the top of the range
    send_frame(lrfp_pkg::CMD_MEASURE, 8'(MAX_FRAME_BYTES - lrfp_pkg::FRAME_OVERHEAD + 1),
               lrfp_pkg::END_MARK);
    send_frame(lrfp_pkg::CMD_PRODUCT, 8'hFF, lrfp_pkg::END_MARK);
    // wrong second header: plain byte, then a repeated first header
    send_byte(lrfp_pkg::HDR_FIRST);
    send_byte(8'h13);
    send_byte(lrfp_pkg::HDR_FIRST);
    payload_q = '{8'h41, 8'h49, 8'h07};
    send_frame(lrfp_pkg::CMD_PRODUCT, 8'd3, lrfp_pkg::END_MARK);
    // wrong end byte: plain byte, then a first header that restarts the frame
    payload_q = '{8'h01, 8'h02, 8'h03};
    send_frame(lrfp_pkg::CMD_MEASURE, 8'd3, 8'h00);
    payload_q = '{8'h04, 8'h05, 8'h06};
    send_frame(lrfp_pkg::CMD_MEASURE, 8'd3, lrfp_pkg::HDR_FIRST);
    send_byte(lrfp_pkg::HDR_SECOND);
    send_byte(lrfp_pkg::CMD_RESET);
    send_byte(8'd0);
    send_byte(lrfp_pkg::END_MARK);

    // random frames, mostly well formed
    while (sent_bytes < RANDOM_BYTES) begin
      if (sent_bytes < RANDOM_BYTES / 3) begin
        send_idle_pct = 13;
        recv_idle_pct = 50;
      end else if (sent_bytes < 2 * RANDOM_BYTES / 3) begin
        send_idle_pct = 50;
        recv_idle_pct = 13;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case ($urandom_range(5))
        0: begin cmd = lrfp_pkg::CMD_MEASURE; len = 8'd3; end
        1: begin cmd = lrfp_pkg::CMD_RESET;   len = 8'd0; end
        2: begin cmd = lrfp_pkg::CMD_FACTORY; len = 8'd7; end
        3: begin cmd = lrfp_pkg::CMD_PRODUCT; len = 8'd3; end
        4: begin cmd = pick_byte(); len = 8'($urandom_range(8)); end
        default: begin cmd = ($urandom_range(1) != 0) ? 8'h82 : 8'h83; len = 8'd1; end
      endcase
      roll = $urandom_range(99);
      if ($urandom_range(99) < 25) len = 8'($urandom_range(10));
      else if ($urandom_range(99) < 5) begin
        len = 8'($urandom_range(MAX_FRAME_BYTES - lrfp_pkg::FRAME_OVERHEAD));
      end
      if (roll < 72) begin
        fill_payload(len);
        send_frame(cmd, len, lrfp_pkg::END_MARK);
      end else if (roll < 78) begin
        repeat ($urandom_range(1, 4)) send_byte(pick_byte());
      end else if (roll < 84) begin
        // broken second header
        send_byte(lrfp_pkg::HDR_FIRST);
        send_byte(pick_byte());
      end else if (roll < 92) begin
        fill_payload(len);
        send_frame(cmd, len, pick_byte());
      end else if (roll < 96) begin
        fill_payload($urandom_range(3));
        send_frame(cmd, 8'($urandom_range(MAX_FRAME_BYTES - lrfp_pkg::FRAME_OVERHEAD + 1,
                                           255)),
                   lrfp_pkg::END_MARK);
      end else begin
        // frame cut short, the next frame runs into its payload
        send_byte(lrfp_pkg::HDR_FIRST);
        send_byte(lrfp_pkg::HDR_SECOND);
        send_byte(cmd);
        send_byte(len);
        repeat ($urandom_range(len)) send_byte(pick_byte());
      end
    end
    in_tvalid <= 1'b0;

    // drain the remaining results
    @(posedge clk);
    while (record_book.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (record_book.mismatches == 0) begin
      $display("lidar_response_frame_parser_unit regression: pass");
    end else begin
      $display("lidar_response_frame_parser_unit regression: fail");
    end
    $finish;
  end

endmodule
